// ===== hdl/assert_macros.svh =====
// assertion macros for the merge engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define GSME_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, named for checks that follow a transfer
`define GSME_ASSERT_XFER(label, clk, rst_n, prop, msg) \
    `GSME_ASSERT(label, clk, rst_n, prop, msg)

`endif

// ===== hdl/gsme_pkg.sv =====
// ----------------------------------------------------------------------------
// gsme_pkg
// types, codes and widths shared by the merge engine modules
// ----------------------------------------------------------------------------
package gsme_pkg;

    localparam int NODES  = 1024;
    localparam int NODE_W = $clog2(NODES);
    localparam int STEP_W = $clog2(NODES + 1);
    localparam int PAR_W  = NODE_W + 1;
    localparam int LBL_W  = 10;
    localparam int CNT_W  = 11;
    localparam int THR_W  = 20;
    localparam int DIV_W  = $clog2(THR_W);
    localparam int CFG_IW = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};
    localparam logic [THR_W-1:0] SCALE_RST = THR_W'(12288);
    localparam logic [CNT_W-1:0] MIN_RST = CNT_W'(3);

    localparam logic [1:0] CMD_THR   = 2'd0;
    localparam logic [1:0] CMD_SMALL = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_SCALE = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_MIN   = CFG_IW'(1);

    localparam logic [2:0] WR_NONE = 3'd0;
    localparam logic [2:0] WR_CLR  = 3'd1;
    localparam logic [2:0] WR_COMP = 3'd2;
    localparam logic [2:0] WR_HI   = 3'd3;
    localparam logic [2:0] WR_LO   = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       find_init;
        logic       find_src_b;
        logic       walk_step;
        logic       cap_a;
        logic       cap_b;
        logic       cap_r;
        logic       set_merged;
        logic       div_start;
        logic       div_step;
        logic       clr_start;
        logic       clr_step;
        logic       out_load;
        logic [2:0] wr_op;
    } t_dp_cmd;

    typedef struct packed {
        logic       walk_more;
        logic       do_thr;
        logic       do_small;
        logic       div_last;
        logic       clr_last;
        logic       out_free;
        logic [1:0] in_cmd;
    } t_dp_stat;

endpackage

// ===== hdl/graph_segmentation_merge_engine.sv =====
// ----------------------------------------------------------------------------
// graph_segmentation_merge_engine
// union-find merge engine for graph segmentation with threshold and size merges
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      i_valid / o_ready         i_command i_node_a i_node_b i_weight
// out       output     o_valid / i_ready         o_merged o_root_label o_component_size
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// one item at a time; a root walk passes S_FRD and S_FCHK once per parent
// link and once more at the root; query: accept, one root walk, result;
// edge: accept, three root walks, decision and result, a union adds the hi
// and lo root writes and a threshold merge a further restoring divide
// clear: accept, a sweep over all 1024 nodes, result; the sweep also runs
// after reset; a stalled result waits in the output register, next item taken
module graph_segmentation_merge_engine import gsme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [LBL_W-1:0]  i_node_a,
    input  logic [LBL_W-1:0]  i_node_b,
    input  logic [THR_W-1:0]  i_weight,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_merged,
    output logic [LBL_W-1:0]  o_root_label,
    output logic [CNT_W-1:0]  o_component_size,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [THR_W-1:0]  i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    gsme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gsme_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_weight         (i_weight),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_merged         (o_merged),
        .o_root_label     (o_root_label),
        .o_component_size (o_component_size)
    );

endmodule

// ===== hdl/gsme_dp.sv =====
// ----------------------------------------------------------------------------
// gsme_dp
// node memories, root walk, merge decision, threshold divider, result register
// ----------------------------------------------------------------------------
module gsme_dp import gsme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [THR_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_command,
    input  logic [LBL_W-1:0]  i_node_a,
    input  logic [LBL_W-1:0]  i_node_b,
    input  logic [THR_W-1:0]  i_weight,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_merged,
    output logic [LBL_W-1:0]  o_root_label,
    output logic [CNT_W-1:0]  o_component_size
);

    logic [PAR_W-1:0] r_par_mem [NODES];
    logic [CNT_W-1:0] r_cnt_mem [NODES];
    logic [THR_W-1:0] r_thr_mem [NODES];
    logic [PAR_W-1:0] r_par_q;
    logic [CNT_W-1:0] r_cnt_q;
    logic [THR_W-1:0] r_thr_q;

    logic [THR_W-1:0]  r_scale;
    logic [CNT_W-1:0]  r_min;
    logic [1:0]        r_cmd;
    logic [NODE_W-1:0] r_a, r_b, r_cur, r_start, r_clr;
    logic [THR_W-1:0]  r_w;
    logic [STEP_W-1:0] r_steps;
    logic              r_start_t;
    logic [NODE_W-1:0] r_ra, r_rb, r_root;
    logic              r_ta, r_tb;
    logic [CNT_W-1:0]  r_ca, r_cb, r_size;
    logic [THR_W-1:0]  r_tha, r_thb;
    logic              r_merged;
    logic [CNT_W:0]    r_rem;
    logic [THR_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_div;
    logic              r_ovalid;
    logic              r_omerged;
    logic [LBL_W-1:0]  r_olabel;
    logic [CNT_W-1:0]  r_osize;

    logic              d_t, t0;
    logic [NODE_W-1:0] d_par;
    logic [CNT_W-1:0]  ca, cb, cmin, sum_sat, cnt_hi;
    logic [THR_W-1:0]  tha, thb, tmin, thr_lo, thr_hi, thr_new;
    logic [CNT_W:0]    sum, trial;
    logic [THR_W:0]    thr_sum;
    logic              a_lo, ne;
    logic [NODE_W-1:0] lo, hi;
    logic [NODE_W-1:0] wr_addr;
    logic              par_we, cnt_we, thr_we;
    logic [PAR_W-1:0]  par_wd;
    logic [CNT_W-1:0]  cnt_wd;
    logic [THR_W-1:0]  thr_wd;

    assign d_t   = r_par_q[NODE_W];
    assign d_par = r_par_q[NODE_W-1:0];
    assign t0    = (r_steps == '0) ? d_t : r_start_t;

    assign ca   = r_ta ? r_ca : CNT_W'(1);
    assign cb   = r_tb ? r_cb : CNT_W'(1);
    assign tha  = r_ta ? r_tha : r_scale;
    assign thb  = r_tb ? r_thb : r_scale;
    assign cmin = (ca < cb) ? ca : cb;
    assign tmin = (tha < thb) ? tha : thb;
    assign ne   = r_ra != r_rb;
    assign a_lo = r_ra < r_rb;
    assign lo   = a_lo ? r_ra : r_rb;
    assign hi   = a_lo ? r_rb : r_ra;
    assign cnt_hi = a_lo ? cb : ca;
    assign thr_lo = a_lo ? tha : thb;
    assign thr_hi = a_lo ? thb : tha;
    assign sum     = {1'b0, ca} + {1'b0, cb};
    assign sum_sat = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    assign trial   = {r_rem[CNT_W-1:0], r_quo[THR_W-1]};
    assign thr_sum = {1'b0, r_w} + {1'b0, r_quo};
    assign thr_new = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];

    always_comb begin
        wr_addr = r_clr;
        par_we  = 1'b0;
        cnt_we  = 1'b0;
        thr_we  = 1'b0;
        par_wd  = {1'b1, lo};
        cnt_wd  = cnt_hi;
        thr_wd  = thr_hi;
        case (i_cmd.wr_op)
            WR_CLR: begin
                par_we = 1'b1;
                par_wd = {1'b0, r_clr};
            end
            WR_COMP: begin
                wr_addr = r_start;
                par_we  = t0;
                par_wd  = {1'b1, r_cur};
            end
            WR_HI: begin
                wr_addr = hi;
                par_we  = 1'b1;
                cnt_we  = 1'b1;
                thr_we  = 1'b1;
            end
            WR_LO: begin
                wr_addr = lo;
                par_we  = 1'b1;
                cnt_we  = 1'b1;
                thr_we  = 1'b1;
                cnt_wd  = sum_sat;
                thr_wd  = (r_cmd == CMD_THR) ? thr_new : thr_lo;
            end
            default: begin
                par_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (par_we) r_par_mem[wr_addr] <= par_wd;
        if (cnt_we) r_cnt_mem[wr_addr] <= cnt_wd;
        if (thr_we) r_thr_mem[wr_addr] <= thr_wd;
        r_par_q <= r_par_mem[r_cur];
        r_cnt_q <= r_cnt_mem[r_cur];
        r_thr_q <= r_thr_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_command;
            r_a   <= NODE_W'(i_node_a);
            r_b   <= NODE_W'(i_node_b);
            r_w   <= i_weight;
        end
        if (i_cmd.load_in || i_cmd.set_merged) begin
            r_merged <= i_cmd.set_merged;
        end
        if (i_cmd.find_init) begin
            if (i_cmd.load_in) begin
                r_cur   <= NODE_W'(i_node_a);
                r_start <= NODE_W'(i_node_a);
            end else begin
                r_cur   <= i_cmd.find_src_b ? r_b : r_a;
                r_start <= i_cmd.find_src_b ? r_b : r_a;
            end
            r_steps <= '0;
        end else if (i_cmd.walk_step) begin
            r_cur   <= d_par;
            r_steps <= r_steps + STEP_W'(1);
        end
        if (i_cmd.walk_step && r_steps == '0) begin
            r_start_t <= d_t;
        end
        if (i_cmd.cap_a) begin
            r_ra  <= r_cur;
            r_ta  <= d_t;
            r_ca  <= r_cnt_q;
            r_tha <= r_thr_q;
        end
        if (i_cmd.cap_b) begin
            r_rb  <= r_cur;
            r_tb  <= d_t;
            r_cb  <= r_cnt_q;
            r_thb <= r_thr_q;
        end
        if (i_cmd.cap_r) begin
            r_root <= r_cur;
            r_size <= d_t ? r_cnt_q : CNT_W'(1);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_scale;
            r_div <= '0;
        end else if (i_cmd.div_step) begin
            if (trial >= {1'b0, sum_sat}) begin
                r_rem <= trial - {1'b0, sum_sat};
                r_quo <= {r_quo[THR_W-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[THR_W-2:0], 1'b0};
            end
            r_div <= r_div + DIV_W'(1);
        end
        if (i_cmd.out_load) begin
            if (r_cmd == CMD_CLEAR) begin
                r_omerged <= 1'b0;
                r_olabel  <= LBL_W'(r_a);
                r_osize   <= CNT_W'(1);
            end else begin
                r_omerged <= r_merged;
                r_olabel  <= LBL_W'(r_root);
                r_osize   <= r_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_min    <= MIN_RST;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_SCALE) r_scale <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_MIN)   r_min   <= i_cfg_data[CNT_W-1:0];
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.walk_more = d_t && (d_par != r_cur) && (r_steps < STEP_W'(NODES));
    assign o_stat.do_thr    = (r_cmd == CMD_THR) && ne && (r_w <= tmin);
    assign o_stat.do_small  = (r_cmd == CMD_SMALL) && ne && (cmin <= r_min);
    assign o_stat.div_last  = r_div == DIV_W'(THR_W - 1);
    assign o_stat.clr_last  = r_clr == NODE_W'(NODES - 1);
    assign o_stat.out_free  = !r_ovalid || i_ready;
    assign o_stat.in_cmd    = i_command;

    assign o_valid          = r_ovalid;
    assign o_merged         = r_omerged;
    assign o_root_label     = r_olabel;
    assign o_component_size = r_osize;

endmodule

// ===== hdl/gsme_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsme_ctrl
// sequencer for clear sweeps, root walks, merge and result hand-off
// ----------------------------------------------------------------------------
module gsme_ctrl import gsme_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_RCLR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CLR  = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FCHK = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_JHI  = 4'd7;
    localparam logic [3:0] S_JLO  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_F = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.wr_op = WR_NONE;
        o_ready = 1'b0;
        case (r_state)
            S_RCLR: begin
                o_cmd.wr_op    = WR_CLR;
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    case (i_stat.in_cmd)
                        CMD_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLR;
                        end
                        CMD_QUERY: begin
                            n_phase = PH_F;
                            n_state = S_FRD;
                        end
                        default: begin
                            n_phase = PH_A;
                            n_state = S_FRD;
                        end
                    endcase
                end
                if (n_state == S_FRD) o_cmd.find_init = 1'b1;
            end
            S_CLR: begin
                o_cmd.wr_op    = WR_CLR;
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                    n_state = S_FRD;
                end else begin
                    o_cmd.wr_op = WR_COMP;
                    case (r_phase)
                        PH_A: begin
                            o_cmd.cap_a      = 1'b1;
                            o_cmd.find_init  = 1'b1;
                            o_cmd.find_src_b = 1'b1;
                            n_phase = PH_B;
                            n_state = S_FRD;
                        end
                        PH_B: begin
                            o_cmd.cap_b = 1'b1;
                            n_state = S_DEC;
                        end
                        default: begin
                            o_cmd.cap_r = 1'b1;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DEC: begin
                if (i_stat.do_thr) begin
                    o_cmd.set_merged = 1'b1;
                    o_cmd.div_start  = 1'b1;
                    n_state = S_DIV;
                end else if (i_stat.do_small) begin
                    o_cmd.set_merged = 1'b1;
                    n_state = S_JHI;
                end else begin
                    o_cmd.find_init = 1'b1;
                    n_phase = PH_F;
                    n_state = S_FRD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_JHI;
            end
            S_JHI: begin
                o_cmd.wr_op = WR_HI;
                n_state = S_JLO;
            end
            S_JLO: begin
                o_cmd.wr_op     = WR_LO;
                o_cmd.find_init = 1'b1;
                n_phase = PH_F;
                n_state = S_FRD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RCLR;
            r_phase <= PH_A;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== hdl/gsme_chk.sv =====
// ----------------------------------------------------------------------------
// gsme_chk
// port-level checks for the merge engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsme_chk import gsme_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_merged,
    input logic [LBL_W-1:0] o_root_label,
    input logic [CNT_W-1:0] o_component_size
);

    `GSME_ASSERT_XFER(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_root_label) && $stable(o_component_size) && $stable(o_merged), "result changed while stalled")
    `GSME_ASSERT(a_size_nonzero, i_clk, i_rst_n, o_valid |-> o_component_size != '0, "component size is zero")
    `GSME_ASSERT(a_merge_size, i_clk, i_rst_n, o_valid && o_merged |-> o_component_size >= CNT_W'(2), "merged component smaller than two")
    `GSME_ASSERT_XFER(a_one_item, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "second item taken while busy")

endmodule

bind graph_segmentation_merge_engine gsme_chk u_gsme_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_merged         (o_merged),
    .o_root_label     (o_root_label),
    .o_component_size (o_component_size)
);

// ===== verif/graph_segmentation_merge_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_segmentation_merge_engine_tb
// drives merge, query and clear transfers into the union-find engine, keeps a
// shadow forest of the segmentation and checks every result in arrival order
// ----------------------------------------------------------------------------
module graph_segmentation_merge_engine_tb;
    import gsme_pkg::*;

    typedef struct packed {
        logic             merged;
        logic [LBL_W-1:0] root;
        logic [CNT_W-1:0] size;
    } t_label;

    class merge_scoreboard;
        logic [NODE_W-1:0] link [NODES];
        logic [CNT_W-1:0]  members [NODES];
        logic [THR_W-1:0]  thr [NODES];
        bit                touched [NODES];
        logic [THR_W-1:0]  scale;
        logic [CNT_W-1:0]  small_limit;
        t_label            pending [$];
        int                errors;

        function new();
            scale = SCALE_RST;
            small_limit = MIN_RST;
            errors = 0;
            foreach (touched[i]) touched[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [THR_W-1:0] d);
            if (idx == CFG_SCALE) scale = d;
            else if (idx == CFG_MIN) small_limit = d[CNT_W-1:0];
        endfunction

        function logic [CNT_W-1:0] count_of(int r);
            return touched[r] ? members[r] : CNT_W'(1);
        endfunction

        function logic [THR_W-1:0] thr_of(int r);
            return touched[r] ? thr[r] : scale;
        endfunction

        function void touch(int n);
            if (!touched[n]) begin
                link[n] = NODE_W'(n);
                members[n] = CNT_W'(1);
                thr[n] = scale;
                touched[n] = 1;
            end
        endfunction

        function int find_root(int n);
            int y;
            int steps;
            y = n;
            steps = 0;
            while (touched[y] && link[y] != y && steps < NODES) begin
                y = link[y];
                steps++;
            end
            if (touched[n]) link[n] = NODE_W'(y);
            return y;
        endfunction

        function int unite(int ra, int rb);
            int lo;
            int hi;
            int sum;
            lo = ra < rb ? ra : rb;
            hi = ra < rb ? rb : ra;
            touch(lo);
            touch(hi);
            link[hi] = NODE_W'(lo);
            sum = members[lo] + members[hi];
            members[lo] = sum > CNT_MAX ? CNT_MAX : CNT_W'(sum);
            return lo;
        endfunction

        function void note_item(logic [1:0] cmd, logic [LBL_W-1:0] a,
                                logic [LBL_W-1:0] b, logic [THR_W-1:0] w);
            t_label e;
            int ra;
            int rb;
            int nr;
            longint t;
            logic [THR_W-1:0] ta;
            logic [THR_W-1:0] tb;
            logic [CNT_W-1:0] ca;
            logic [CNT_W-1:0] cb;
            e.merged = 0;
            if (cmd == CMD_CLEAR) begin
                foreach (touched[i]) touched[i] = 0;
                e.root = a;
                e.size = CNT_W'(1);
                pending = {pending, e};
                return;
            end
            if (cmd == CMD_THR || cmd == CMD_SMALL) begin
                ra = find_root(a);
                rb = find_root(b);
                if (ra != rb) begin
                    if (cmd == CMD_THR) begin
                        ta = thr_of(ra);
                        tb = thr_of(rb);
                        if (w <= (ta < tb ? ta : tb)) begin
                            nr = unite(ra, rb);
                            t = w + (members[nr] != 0 ? scale / members[nr] : scale);
                            thr[nr] = t > THR_MAX ? THR_MAX : THR_W'(t);
                            e.merged = 1;
                        end
                    end else begin
                        ca = count_of(ra);
                        cb = count_of(rb);
                        if ((ca < cb ? ca : cb) <= small_limit) begin
                            void'(unite(ra, rb));
                            e.merged = 1;
                        end
                    end
                end
            end
            nr = find_root(a);
            e.root = LBL_W'(nr);
            e.size = count_of(nr);
            pending = {pending, e};
        endfunction

        function void check_result(t_label got);
            t_label e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result merged=%0d root=%0d size=%0d",
                         $time, got.merged, got.root, got.size);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.merged !== e.merged) begin
                $display("%0t: merged expected %0d actual %0d", $time, e.merged, got.merged);
                errors++;
            end
            if (got.root !== e.root) begin
                $display("%0t: root_label expected %0d actual %0d", $time, e.root, got.root);
                errors++;
            end
            if (got.size !== e.size) begin
                $display("%0t: component_size expected %0d actual %0d",
                         $time, e.size, got.size);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_command;
    logic [LBL_W-1:0]  i_node_a;
    logic [LBL_W-1:0]  i_node_b;
    logic [THR_W-1:0]  i_weight;
    logic              o_valid;
    logic              i_ready;
    logic              o_merged;
    logic [LBL_W-1:0]  o_root_label;
    logic [CNT_W-1:0]  o_component_size;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [THR_W-1:0]  i_cfg_data;

    merge_scoreboard board;
    int  idle_cycles;
    bit  calm;
    bit  hold_out;
    logic [THR_W-1:0] weight_now;

    graph_segmentation_merge_engine uut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        i_rst_n = 0;
        i_valid = 0;
        i_command = CMD_QUERY;
        i_node_a = 0;
        i_node_b = 0;
        i_weight = 0;
        i_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_SCALE;
        i_cfg_data = 0;
        calm = 0;
        hold_out = 0;
        weight_now = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid && i_ready) begin
                board.check_result({o_merged, o_root_label, o_component_size});
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("graph_segmentation_merge_engine_tb failed");
                $finish;
            end
            i_ready <= !hold_out && (calm || $urandom_range(99) >= 7);
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [LBL_W-1:0] a,
                             logic [LBL_W-1:0] b, logic [THR_W-1:0] w);
        while (!calm && $urandom_range(99) < 7) @(posedge i_clk);
        i_valid <= 1;
        i_command <= cmd;
        i_node_a <= a;
        i_node_b <= b;
        i_weight <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_item(cmd, a, b, w);
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [THR_W-1:0] d);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(idx, d);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int span);
        int k;
        int a;
        logic [1:0] cmd;
        for (k = 0; k < count; k++) begin
            a = $urandom_range(span);
            case ($urandom_range(19))
                0: cmd = CMD_CLEAR;
                1, 2, 3: cmd = CMD_QUERY;
                4, 5, 6, 7: cmd = CMD_SMALL;
                default: cmd = CMD_THR;
            endcase
            if (cmd == CMD_CLEAR) weight_now = 0;
            if ($urandom_range(9) == 0)
                weight_now = THR_W'($urandom);
            else if (weight_now < THR_MAX - 2000)
                weight_now = THR_W'(weight_now + $urandom_range(2000));
            if ($urandom_range(15) == 0)
                send_item(cmd, LBL_W'($urandom), LBL_W'($urandom), THR_W'($urandom));
            else
                send_item(cmd, LBL_W'(a), LBL_W'($urandom_range(span)), weight_now);
        end
    endtask

    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_QUERY, 1023, 0, 0);
        send_item(CMD_THR, 5, 6, 0);
        send_item(CMD_THR, 6, 5, 10);
        send_item(CMD_THR, 7, 8, 20'hFFFFF);
        send_item(CMD_THR, 1023, 1022, 100);
        send_item(CMD_THR, 0, 1023, 200);
        send_item(CMD_SMALL, 5, 7, 0);
        send_item(CMD_SMALL, 0, 5, 0);
        send_item(CMD_SMALL, 9, 9, 0);
        send_item(CMD_QUERY, 1022, 1023, 0);
        send_item(CMD_QUERY, 6, 0, 0);
        send_item(CMD_CLEAR, 1023, 1023, 20'hFFFFF);
        send_item(CMD_QUERY, 6, 0, 0);
        write_reg(CFG_SCALE, 20'hFFFFF);
        write_reg(CFG_MIN, 0);
        send_item(CMD_THR, 1, 2, 20'hFFFF0);
        send_item(CMD_THR, 2, 3, 20'hFFFFF);
        send_item(CMD_SMALL, 1, 4, 0);
        send_item(CMD_THR, 4, 1, 20'hFFFFF);
        write_reg(CFG_MIN, THR_W'(1024));
        send_item(CMD_SMALL, 1, 4, 0);
        send_item(CMD_CLEAR, 0, 0, 0);
        calm = 1;
        random_phase(60, 15);
        calm = 0;
        write_reg(CFG_SCALE, 0);
        write_reg(CFG_MIN, THR_W'(3));
        random_phase(60, 31);
        write_reg(CFG_SCALE, THR_W'(12288));
        random_phase(100, 63);
        fork
            begin
                hold_out = 1;
                repeat (300) @(posedge i_clk);
                hold_out = 0;
            end
            random_phase(30, 15);
        join
        write_reg(CFG_SCALE, THR_W'($urandom));
        write_reg(CFG_MIN, THR_W'($urandom_range(1024)));
        random_phase(80, 1023);
        write_reg(CFG_SCALE, 20'hFFFFF);
        random_phase(50, 7);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0)
            $display("graph_segmentation_merge_engine_tb passed");
        else
            $display("graph_segmentation_merge_engine_tb failed");
        $finish;
    end
endmodule

// ===== graph_segmentation_merge_engine.f =====
+incdir+hdl
hdl/gsme_pkg.sv
hdl/gsme_dp.sv
hdl/gsme_ctrl.sv
hdl/graph_segmentation_merge_engine.sv
hdl/gsme_chk.sv
verif/graph_segmentation_merge_engine_tb.sv
